### design/gsk_pkg.sv
// gsk_pkg: shared types, constants and the sigmoid table of the gated sensor kinetics step
// no dependencies; imported by every module of the block

package gsk_pkg;

    // fixed-point layout
    localparam int GATE_FRAC_BITS = 16;
    localparam int GATE_W         = GATE_FRAC_BITS;
    localparam int SIG_ENTRIES    = 256;
    localparam int SIG_IDX_W      = $clog2(SIG_ENTRIES);
    localparam int MUL_W          = (GATE_W + 1 > 17) ? GATE_W + 1 : 17;
    localparam int ACC_W          = 2 * MUL_W;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [63:0] EINV_Q32   = 64'd1580030169;
    localparam logic [63:0] ESTEP_Q32  = 64'd4278222805;
    localparam logic [63:0] Q32_ONE    = 64'h1_0000_0000;
    localparam logic [63:0] Q32_HALF   = 64'h8000_0000;
    localparam logic [63:0] GATE_MAX64 = (64'd1 << GATE_W) - 64'd1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY_M    = 3'd0,
        CFG_DECAY_H    = 3'd1,
        CFG_DECAY_AVG  = 3'd2,
        CFG_OFFSET_M   = 3'd3,
        CFG_OFFSET_H   = 3'd4,
        CFG_VALUE_MAX  = 3'd5,
        CFG_EXPONENT_M = 3'd6,
        CFG_EXPONENT_H = 3'd7
    } cfg_idx_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOOK,
        OP_BLEND_M1,
        OP_BLEND_M2,
        OP_BLEND_H1,
        OP_BLEND_H2,
        OP_POW_INIT,
        OP_POW_M,
        OP_POW_H,
        OP_VALUE,
        OP_AVG1,
        OP_AVG2,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] exp_m;
        logic [1:0] exp_h;
    } status_t;

    typedef logic [GATE_W-1:0] sig_rom_t [SIG_ENTRIES];

    // sigmoid table built at elaboration: e^-|x| by repeated rounded products,
    // then a rounded restoring division
    function automatic sig_rom_t sig_rom_build();
        sig_rom_t    rom;
        int          k;
        int          i;
        int          b;
        int          x;
        int          y;
        logic [63:0] r;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        for (k = 0; k < SIG_ENTRIES; k++) begin
            x = -2048 + (k * 4096) / SIG_ENTRIES;
            y = (x < 0) ? -x : x;
            r = Q32_ONE;
            for (i = 0; i < (y >> 8); i++) begin
                r = (r * EINV_Q32 + Q32_HALF) >> 32;
            end
            for (i = 0; i < (y & 255); i++) begin
                r = (r * ESTEP_Q32 + Q32_HALF) >> 32;
            end
            den = Q32_ONE + r;
            num = (x >= 0) ? (r << GATE_FRAC_BITS) : (64'd1 << (32 + GATE_FRAC_BITS));
            n = (num << 1) + den;
            d = den << 1;
            q = 64'd0;
            for (b = GATE_W + 1; b >= 0; b--) begin
                if (n >= (d << b)) begin
                    n = n - (d << b);
                    q = q | (64'd1 << b);
                end
            end
            if (q > GATE_MAX64) begin
                q = GATE_MAX64;
            end
            rom[k] = q[GATE_W-1:0];
        end
        return rom;
    endfunction

    localparam sig_rom_t SIG_ROM = sig_rom_build();

    // clamp the argument to about +-8 and map it to a table index
    function automatic logic [SIG_IDX_W-1:0] sig_index(logic signed [17:0] arg);
        logic signed [17:0]         c;
        logic [11:0]                u;
        logic [SIG_IDX_W+12:0]      p;
        c = arg;
        if (arg < -18'sd2048) begin
            c = -18'sd2048;
        end else if (arg > 18'sd2047) begin
            c = 18'sd2047;
        end
        u = 12'(c + 18'sd2048);
        p = (SIG_IDX_W + 13)'(u) * (SIG_IDX_W + 13)'(SIG_ENTRIES);
        return p[SIG_IDX_W+11:12];
    endfunction

    // gate in Q0.F to Q0.16
    function automatic logic [15:0] to_q16(logic [GATE_W-1:0] g);
        logic [GATE_W+15:0] w;
        w = {g, 16'd0} >> GATE_FRAC_BITS;
        return w[15:0];
    endfunction

endpackage

### design/gated_sensor_kinetics_step_core.sv
// gated_sensor_kinetics_step_core: top level of the gated sensor kinetics step
// depends on gsk_pkg, gsk_ctrl and gsk_dpath

// One accepted current sample (signed Q8.8) advances the activation and inactivation
// gates one exponential-Euler step toward their sigmoid targets, forms
// value_max * m^exponent_m * h^exponent_h (Q8.8, saturating) and updates the running
// average; the result carries the new gates in Q0.16, the value and the average.
// Items are handled one at a time on a single shared 17x17 multiplier: an item goes
// through capture, table lookup, four blend steps, power setup, one step per gate
// power, value, two averaging steps and output load before the next transfer is taken.
// The result sits in an output register, so the next sample is taken while it waits;
// the step after that stalls until the result transfer completes. The 256-entry sigmoid
// table is a constant built at elaboration. Registers are to be written by the user
// through cfg_wr_en/cfg_index/cfg_wdata only while idle; the block does not enforce it.

module gated_sensor_kinetics_step_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [gsk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsk_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [15:0]                 s_current,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [15:0]                        m_gate_act,
    output logic [15:0]                        m_gate_inact,
    output logic [15:0]                        m_sensor_value,
    output logic [15:0]                        m_average_value
);
    import gsk_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing
    gsk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic and state
    gsk_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_current       (s_current),
        .cmd             (cmd),
        .status          (status),
        .m_gate_act      (m_gate_act),
        .m_gate_inact    (m_gate_inact),
        .m_sensor_value  (m_sensor_value),
        .m_average_value (m_average_value)
    );

endmodule

### design/gsk_ctrl.sv
// gsk_ctrl: sequencing state machine of the gated sensor kinetics step
// depends on gsk_pkg; drives the datapath gsk_dpath through cmd_t

module gsk_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  gsk_pkg::status_t  status,
    output gsk_pkg::cmd_t     cmd
);
    import gsk_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_LOOK     = 13'b0000000000010,
        ST_BLEND_M1 = 13'b0000000000100,
        ST_BLEND_M2 = 13'b0000000001000,
        ST_BLEND_H1 = 13'b0000000010000,
        ST_BLEND_H2 = 13'b0000000100000,
        ST_POW_INIT = 13'b0000001000000,
        ST_POW_M    = 13'b0000010000000,
        ST_POW_H    = 13'b0000100000000,
        ST_VALUE    = 13'b0001000000000,
        ST_AVG1     = 13'b0010000000000,
        ST_AVG2     = 13'b0100000000000,
        ST_FIN      = 13'b1000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // next state, power counter and command
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        cmd.op       = OP_NONE;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                cmd.op     = OP_LOOK;
                state_next = ST_BLEND_M1;
            end
            ST_BLEND_M1: begin
                cmd.op     = OP_BLEND_M1;
                state_next = ST_BLEND_M2;
            end
            ST_BLEND_M2: begin
                cmd.op     = OP_BLEND_M2;
                state_next = ST_BLEND_H1;
            end
            ST_BLEND_H1: begin
                cmd.op     = OP_BLEND_H1;
                state_next = ST_BLEND_H2;
            end
            ST_BLEND_H2: begin
                cmd.op     = OP_BLEND_H2;
                state_next = ST_POW_INIT;
            end
            ST_POW_INIT: begin
                cmd.op = OP_POW_INIT;
                if (status.exp_m != 2'd0) begin
                    cnt_next   = status.exp_m;
                    state_next = ST_POW_M;
                end else if (status.exp_h != 2'd0) begin
                    cnt_next   = status.exp_h;
                    state_next = ST_POW_H;
                end else begin
                    state_next = ST_VALUE;
                end
            end
            ST_POW_M: begin
                cmd.op = OP_POW_M;
                if (cnt_reg == 2'd1) begin
                    if (status.exp_h != 2'd0) begin
                        cnt_next   = status.exp_h;
                        state_next = ST_POW_H;
                    end else begin
                        state_next = ST_VALUE;
                    end
                end else begin
                    cnt_next = cnt_reg - 2'd1;
                end
            end
            ST_POW_H: begin
                cmd.op = OP_POW_H;
                if (cnt_reg == 2'd1) begin
                    state_next = ST_VALUE;
                end else begin
                    cnt_next = cnt_reg - 2'd1;
                end
            end
            ST_VALUE: begin
                cmd.op     = OP_VALUE;
                state_next = ST_AVG1;
            end
            ST_AVG1: begin
                cmd.op     = OP_AVG1;
                state_next = ST_AVG2;
            end
            ST_AVG2: begin
                cmd.op     = OP_AVG2;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // load the output register once the previous result is gone
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### design/gsk_dpath.sv
// gsk_dpath: configuration registers, gate state and shared multiplier datapath
// depends on gsk_pkg (sigmoid table, helpers); commanded by gsk_ctrl

module gsk_dpath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [gsk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsk_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic signed [15:0]                 s_current,
    input  gsk_pkg::cmd_t                      cmd,
    output gsk_pkg::status_t                   status,
    output logic [15:0]                        m_gate_act,
    output logic [15:0]                        m_gate_inact,
    output logic [15:0]                        m_sensor_value,
    output logic [15:0]                        m_average_value
);
    import gsk_pkg::*;

    // configuration
    logic [15:0]        decay_m_reg, decay_h_reg, decay_avg_reg, value_max_reg;
    logic signed [15:0] offset_m_reg, offset_h_reg;
    logic [1:0]         exp_m_reg, exp_h_reg;

    // step state and working registers
    logic signed [15:0] cur_reg;
    logic [GATE_W-1:0]  tgt_m_reg, tgt_h_reg;
    logic [GATE_W-1:0]  act_reg, inact_reg;
    logic [GATE_W:0]    prod_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [15:0]        val_reg, avg_reg;
    logic [15:0]        out_act_reg, out_inact_reg, out_val_reg, out_avg_reg;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [ACC_W-1:0]   mul_p;
    logic [ACC_W:0]     blend_sum, blend_shr, round_sum, round_shr;
    logic signed [17:0] arg_m, arg_h;
    logic [15:0]        val_sat;

    assign status.exp_m = exp_m_reg;
    assign status.exp_h = exp_h_reg;

    assign m_gate_act      = out_act_reg;
    assign m_gate_inact    = out_inact_reg;
    assign m_sensor_value  = out_val_reg;
    assign m_average_value = out_avg_reg;

    // sigmoid arguments: offset_m + I and -I - offset_h
    assign arg_m = 18'(offset_m_reg) + 18'(cur_reg);
    assign arg_h = 18'sd0 - 18'(cur_reg) - 18'(offset_h_reg);

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_BLEND_M1: begin
                mul_a = MUL_W'(tgt_m_reg);
                mul_b = MUL_W'(17'h10000 - 17'(decay_m_reg));
            end
            OP_BLEND_M2: begin
                mul_a = MUL_W'(act_reg);
                mul_b = MUL_W'(decay_m_reg);
            end
            OP_BLEND_H1: begin
                mul_a = MUL_W'(tgt_h_reg);
                mul_b = MUL_W'(17'h10000 - 17'(decay_h_reg));
            end
            OP_BLEND_H2: begin
                mul_a = MUL_W'(inact_reg);
                mul_b = MUL_W'(decay_h_reg);
            end
            OP_POW_M: begin
                mul_a = MUL_W'(prod_reg);
                mul_b = MUL_W'(act_reg);
            end
            OP_POW_H: begin
                mul_a = MUL_W'(prod_reg);
                mul_b = MUL_W'(inact_reg);
            end
            OP_VALUE: begin
                mul_a = MUL_W'(value_max_reg);
                mul_b = MUL_W'(prod_reg);
            end
            OP_AVG1: begin
                mul_a = MUL_W'(val_reg);
                mul_b = MUL_W'(17'h10000 - 17'(decay_avg_reg));
            end
            OP_AVG2: begin
                mul_a = MUL_W'(avg_reg);
                mul_b = MUL_W'(decay_avg_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = ACC_W'(mul_a) * ACC_W'(mul_b);

    // second half of a blend: add to the first product and round off 16 bits
    assign blend_sum = {1'b0, acc_reg} + {1'b0, mul_p} + (ACC_W + 1)'(32768);
    assign blend_shr = blend_sum >> 16;

    // gate products and the value: round off the gate fraction
    assign round_sum = {1'b0, mul_p} + ((ACC_W + 1)'(1) << (GATE_FRAC_BITS - 1));
    assign round_shr = round_sum >> GATE_FRAC_BITS;
    assign val_sat   = (|round_shr[ACC_W:16]) ? 16'hFFFF : round_shr[15:0];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_m_reg   <= 16'd65000;
            decay_h_reg   <= 16'd65000;
            decay_avg_reg <= 16'd65500;
            offset_m_reg  <= 16'sd0;
            offset_h_reg  <= 16'sd0;
            value_max_reg <= 16'd256;
            exp_m_reg     <= 2'd1;
            exp_h_reg     <= 2'd0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DECAY_M:    decay_m_reg   <= cfg_wdata;
                CFG_DECAY_H:    decay_h_reg   <= cfg_wdata;
                CFG_DECAY_AVG:  decay_avg_reg <= cfg_wdata;
                CFG_OFFSET_M:   offset_m_reg  <= $signed(cfg_wdata);
                CFG_OFFSET_H:   offset_h_reg  <= $signed(cfg_wdata);
                CFG_VALUE_MAX:  value_max_reg <= cfg_wdata;
                CFG_EXPONENT_M: exp_m_reg     <= cfg_wdata[1:0];
                CFG_EXPONENT_H: exp_h_reg     <= cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // carried state: gates and running average
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg   <= '0;
            inact_reg <= '0;
            avg_reg   <= '0;
        end else begin
            case (cmd.op)
                OP_BLEND_M2: act_reg   <= blend_shr[GATE_W-1:0];
                OP_BLEND_H2: inact_reg <= blend_shr[GATE_W-1:0];
                OP_AVG2:     avg_reg   <= blend_shr[15:0];
                default: begin
                end
            endcase
        end
    end

    // working registers of one step
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CAPTURE: cur_reg <= s_current;
            OP_LOOK: begin
                tgt_m_reg <= SIG_ROM[sig_index(arg_m)];
                tgt_h_reg <= SIG_ROM[sig_index(arg_h)];
            end
            OP_BLEND_M1: acc_reg  <= mul_p;
            OP_BLEND_H1: acc_reg  <= mul_p;
            OP_AVG1:     acc_reg  <= mul_p;
            OP_POW_INIT: prod_reg <= (GATE_W + 1)'(1) << GATE_FRAC_BITS;
            OP_POW_M:    prod_reg <= round_shr[GATE_W:0];
            OP_POW_H:    prod_reg <= round_shr[GATE_W:0];
            OP_VALUE:    val_reg  <= val_sat;
            OP_OUT: begin
                out_act_reg   <= to_q16(act_reg);
                out_inact_reg <= to_q16(inact_reg);
                out_val_reg   <= val_reg;
                out_avg_reg   <= avg_reg;
            end
            default: begin
            end
        endcase
    end

endmodule

### tb/sv/gated_sensor_kinetics_step_core_tb.sv
`timescale 1ns / 100ps
// gated_sensor_kinetics_step_core_tb: self-checking bench for the gated sensor kinetics step
// depends on gsk_pkg (register indexes) and gated_sensor_kinetics_step_core

module gated_sensor_kinetics_step_core_tb;

    import gsk_pkg::*;

    localparam int          GATE_BITS = 16;
    localparam int          ROM_SIZE  = 256;
    localparam logic [63:0] GATE_TOP  = (64'd1 << GATE_BITS) - 64'd1;
    // e^-1 and e^-1/256 in Q0.32
    localparam logic [127:0] EXP_UNIT = 128'd1580030169;
    localparam logic [127:0] EXP_TICK = 128'd4278222805;

    typedef struct packed {
        logic [15:0] gate_act;
        logic [15:0] gate_inact;
        logic [15:0] sensor_value;
        logic [15:0] average_value;
    } sensor_result_t;

    logic                     aclk            = 1'b0;
    logic                     aresetn         = 1'b0;
    logic                     cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index       = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata       = '0;
    logic                     s_valid         = 1'b0;
    logic                     s_ready;
    logic signed [15:0]       s_current       = '0;
    logic                     m_valid;
    logic                     m_ready         = 1'b0;
    logic [15:0]              m_gate_act;
    logic [15:0]              m_gate_inact;
    logic [15:0]              m_sensor_value;
    logic [15:0]              m_average_value;

    // stimulus and scoreboard state
    logic signed [15:0]       pending_currents [$];
    sensor_result_t           expected_results [$];
    int                       src_idle_pct    = 0;
    int                       snk_stall_pct   = 0;
    logic                     hold_start      = 1'b0;
    logic                     hold_active     = 1'b0;
    int                       fail_count      = 0;

    // predictor state: sigmoid table, registers and gates
    logic [15:0]              sigmoid_rom [0:ROM_SIZE-1];
    logic [15:0]              k_decay_m;
    logic [15:0]              k_decay_h;
    logic [15:0]              k_decay_avg;
    logic signed [15:0]       k_offset_m;
    logic signed [15:0]       k_offset_h;
    logic [15:0]              k_value_max;
    logic [1:0]               k_exp_m;
    logic [1:0]               k_exp_h;
    logic [63:0]              gate_m;
    logic [63:0]              gate_h;
    logic [63:0]              avg_q88;

    gated_sensor_kinetics_step_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_current       (s_current),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_gate_act      (m_gate_act),
        .m_gate_inact    (m_gate_inact),
        .m_sensor_value  (m_sensor_value),
        .m_average_value (m_average_value)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // sigmoid table: e^-|x| by repeated rounded products, then a rounded quotient
    function automatic void build_sigmoid_rom();
        int           k;
        int           i;
        int           x;
        int           y;
        logic [127:0] e;
        logic [127:0] den;
        logic [127:0] num;
        logic [127:0] q;
        for (k = 0; k < ROM_SIZE; k++) begin
            x = -2048 + (k * 4096) / ROM_SIZE;
            y = (x < 0) ? -x : x;
            e = 128'd1 << 32;
            for (i = 0; i < (y >> 8); i++) begin
                e = (e * EXP_UNIT + (128'd1 << 31)) >> 32;
            end
            for (i = 0; i < (y & 255); i++) begin
                e = (e * EXP_TICK + (128'd1 << 31)) >> 32;
            end
            den = (128'd1 << 32) + e;
            num = (x >= 0) ? (e << GATE_BITS) : (128'd1 << (32 + GATE_BITS));
            q = (2 * num + den) / (2 * den);
            sigmoid_rom[k] = (q > GATE_TOP) ? GATE_TOP[15:0] : q[15:0];
        end
    endfunction

    function automatic logic [63:0] sigmoid_at(int arg);
        int c;
        int idx;
        c = (arg < -2048) ? -2048 : ((arg > 2047) ? 2047 : arg);
        idx = ((c + 2048) * ROM_SIZE) >> 12;
        if (idx >= ROM_SIZE) begin
            idx = ROM_SIZE - 1;
        end
        return 64'(sigmoid_rom[idx]);
    endfunction

    // first-order relaxation of old toward target with decay d
    function automatic logic [63:0] relax(logic [63:0] target, logic [63:0] old,
                                          logic [15:0] d);
        return (target * (64'd65536 - 64'(d)) + old * 64'(d) + 64'd32768) >> 16;
    endfunction

    function automatic logic [63:0] gate_mul(logic [63:0] a, logic [63:0] b);
        return (a * b + (64'd1 << (GATE_BITS - 1))) >> GATE_BITS;
    endfunction

    // one time step: gates, sensor value, running average
    function automatic sensor_result_t advance_sensor(logic signed [15:0] cur);
        int             arg_m;
        int             arg_h;
        int             i;
        logic [63:0]    prod;
        logic [63:0]    val;
        sensor_result_t r;
        arg_m = int'(k_offset_m) + int'(cur);
        arg_h = -int'(cur) - int'(k_offset_h);
        gate_m = relax(sigmoid_at(arg_m), gate_m, k_decay_m);
        gate_h = relax(sigmoid_at(arg_h), gate_h, k_decay_h);
        prod = 64'd1 << GATE_BITS;
        for (i = 0; i < k_exp_m; i++) begin
            prod = gate_mul(prod, gate_m);
        end
        for (i = 0; i < k_exp_h; i++) begin
            prod = gate_mul(prod, gate_h);
        end
        val = (64'(k_value_max) * prod + (64'd1 << (GATE_BITS - 1))) >> GATE_BITS;
        if (val > 64'd65535) begin
            val = 64'd65535;
        end
        avg_q88 = relax(val, avg_q88, k_decay_avg) & 64'hFFFF;
        r.gate_act      = gate_m[15:0];
        r.gate_inact    = gate_h[15:0];
        r.sensor_value  = val[15:0];
        r.average_value = avg_q88[15:0];
        return r;
    endfunction

    // register write on the configuration port, mirrored into the predictor
    task automatic cfg_write(cfg_idx_t idx, logic [15:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_DECAY_M:    k_decay_m   = data;
            CFG_DECAY_H:    k_decay_h   = data;
            CFG_DECAY_AVG:  k_decay_avg = data;
            CFG_OFFSET_M:   k_offset_m  = data;
            CFG_OFFSET_H:   k_offset_h  = data;
            CFG_VALUE_MAX:  k_value_max = data;
            CFG_EXPONENT_M: k_exp_m     = data[1:0];
            CFG_EXPONENT_H: k_exp_h     = data[1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_regs(logic [15:0] dm, logic [15:0] dh, logic [15:0] da,
                                logic [15:0] om, logic [15:0] oh, logic [15:0] vm,
                                logic [1:0] em, logic [1:0] eh);
        cfg_write(CFG_DECAY_M, dm);
        cfg_write(CFG_DECAY_H, dh);
        cfg_write(CFG_DECAY_AVG, da);
        cfg_write(CFG_OFFSET_M, om);
        cfg_write(CFG_OFFSET_H, oh);
        cfg_write(CFG_VALUE_MAX, vm);
        cfg_write(CFG_EXPONENT_M, {14'd0, em});
        cfg_write(CFG_EXPONENT_H, {14'd0, eh});
    endtask

    function automatic logic [15:0] pick_decay();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(65535, 40000));
        endcase
    endfunction

    function automatic logic [15:0] pick_offset();
        if ($urandom_range(3) == 0) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(2048) - 1024);
    endfunction

    task automatic program_random_regs();
        program_regs(pick_decay(), pick_decay(), pick_decay(), pick_offset(), pick_offset(),
                     16'($urandom), 2'($urandom), 2'($urandom));
    endtask

    // random currents, mostly inside the sigmoid's live range, some held for a few steps
    task automatic queue_random_currents(int n);
        int                 i;
        int                 run;
        logic signed [15:0] cur;
        i = 0;
        while (i < n) begin
            if ($urandom_range(2) == 0) begin
                cur = 16'($urandom);
            end else begin
                cur = 16'($urandom_range(5120) - 2560);
            end
            run = ($urandom_range(4) == 0) ? $urandom_range(8, 2) : 1;
            repeat (run) begin
                pending_currents.push_back(cur);
                i++;
            end
        end
    endtask

    // let the phase run until every item is accepted and every result has arrived
    task automatic run_phase(int src_pct, int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        do begin
            @(negedge aclk);
        end while (pending_currents.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // driver: offers the next pending current, predicts the result at each transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(advance_sensor(s_current));
            end
            if (!s_valid || s_ready) begin
                if (pending_currents.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_current <= pending_currents.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each result transfer with the oldest prediction
    always @(posedge aclk) begin
        sensor_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no prediction waiting");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("gate_act", want.gate_act, m_gate_act);
                    check_field("gate_inact", want.gate_inact, m_gate_inact);
                    check_field("sensor_value", want.sensor_value, m_sensor_value);
                    check_field("average_value", want.average_value, m_average_value);
                end
            end
            if (hold_active) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    initial begin
        wait (hold_start);
        hold_active <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_active <= 1'b0;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int ph;
        build_sigmoid_rom();
        k_decay_m   = 16'd65000;
        k_decay_h   = 16'd65000;
        k_decay_avg = 16'd65500;
        k_offset_m  = 16'sd0;
        k_offset_h  = 16'sd0;
        k_value_max = 16'd256;
        k_exp_m     = 2'd1;
        k_exp_h     = 2'd0;
        gate_m      = 64'd0;
        gate_h      = 64'd0;
        avg_q88     = 64'd0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: clamp edges, zero, sign bits
        @(negedge aclk);
        pending_currents = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd2047, -16'sd2048,
                             16'sd2048, -16'sd2049, 16'sd1, -16'sd1, 16'sh5555, 16'shAAAA};
        run_phase(0, 0);

        // extreme settings: activation gate jumps straight to target, inactivation gate nearly holds, highest powers
        program_regs(16'd0, 16'hFFFF, 16'd0, 16'h8000, 16'h7FFF, 16'hFFFF, 2'd3, 2'd3);
        @(negedge aclk);
        pending_currents = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                             16'sd0, 16'sd1000};
        run_phase(23, 23);

        // both exponents zero: value follows value_max alone
        program_regs(16'hFFFF, 16'd0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 2'd0, 2'd0);
        @(negedge aclk);
        pending_currents = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd300, -16'sd300};
        run_phase(0, 65);

        // back-pressure: sender keeps offering while the receiver holds off
        program_random_regs();
        @(negedge aclk);
        queue_random_currents(40);
        hold_start = 1'b1;
        run_phase(0, 0);

        // random settings across the idling modes
        for (ph = 0; ph < 8; ph++) begin
            program_random_regs();
            @(negedge aclk);
            queue_random_currents(55);
            case (ph % 4)
                0:       run_phase(0, 0);
                1:       run_phase(65, 0);
                2:       run_phase(0, 65);
                default: run_phase(23, 23);
            endcase
        end

        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
